[hw/rtl/positional_list_engine_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ple_pkg.sv]
package ple_pkg;

  localparam int Depth = 128;
  localparam int WordW = 32;
  localparam int PosW  = 8;
  localparam int CntW  = 8;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LOAD  = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } sel_t;

  typedef struct packed {
    sel_t sel;
    logic rd_en;
  } cell_ctl_t;

  typedef struct packed {
    status_t               status;
    logic [CntW-1:0]       count_next;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  find_ok;
  } dec_t;

endpackage

[hw/rtl/ple_if.sv]
interface ple_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [ple_pkg::PosW-1:0]            position;
  logic signed [ple_pkg::WordW-1:0]    value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface ple_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [ple_pkg::WordW-1:0]    read_value;
  logic [ple_pkg::CntW-1:0]            count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

[hw/rtl/positional_list_engine_unit.sv]
// A response is presented in the cycle after its request transaction.
// Throughput: one transaction per cycle while the response side keeps ready high;
//   every cell of the row shifts in the same cycle, so the cell row bounds the rate at one operation per clock.
// Reset (rst, synchronous): clears the entry count and the response valid;
//   the stored words are not reset and are read only after being written.
module positional_list_engine_unit (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int IdxW = ple_pkg::PosW + 1;

  logic [ple_pkg::CntW-1:0]             count;
  logic                                 rsp_valid;
  ple_pkg::status_t                     rsp_status;
  logic signed [ple_pkg::WordW-1:0]     rsp_read;
  logic [ple_pkg::CntW-1:0]             rsp_count;

  logic                                 accept;
  ple_pkg::dec_t                        dec;
  logic [IdxW-1:0]                      pos_x;
  logic [IdxW-1:0]                      cnt_x;
  logic signed [ple_pkg::WordW-1:0]     read_word;

  logic signed [ple_pkg::WordW-1:0]     cell_word [ple_pkg::Depth];
  logic signed [ple_pkg::WordW-1:0]     cell_rd   [ple_pkg::Depth];
  ple_pkg::cell_ctl_t                   cell_ctl  [ple_pkg::Depth];

  // Accept whenever the response register is empty or being drained.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  ple_ctrl u_ctrl (
    .accept   (accept),
    .func     (req.func),
    .position (req.position),
    .count    (count),
    .dec      (dec)
  );

  assign pos_x = {1'b0, req.position};
  assign cnt_x = IdxW'(count);

  // Row of cells: cell i holds list position i+1.
  // Insert: the target cell loads the word, later live cells take their left
  // neighbor. Delete: cells from the target up to the last-but-one live cell
  // take their right neighbor. Find: only the target cell drives its word.
  for (genvar i = 0; i < ple_pkg::Depth; i++) begin : g_cell
    localparam logic [IdxW-1:0] Idx1 = IdxW'(i + 1);

    logic signed [ple_pkg::WordW-1:0] left_w;
    logic signed [ple_pkg::WordW-1:0] right_w;

    always_comb begin
      cell_ctl[i]       = '0;
      cell_ctl[i].sel   = ple_pkg::SEL_HOLD;
      cell_ctl[i].rd_en = dec.find_ok && (Idx1 == pos_x);
      if (dec.ins_ok) begin
        if (Idx1 == pos_x) begin
          cell_ctl[i].sel = ple_pkg::SEL_LOAD;
        end else if (Idx1 > pos_x && Idx1 <= cnt_x + 1'b1) begin
          cell_ctl[i].sel = ple_pkg::SEL_LEFT;
        end
      end else if (dec.del_ok) begin
        if (Idx1 >= pos_x && Idx1 < cnt_x) begin
          cell_ctl[i].sel = ple_pkg::SEL_RIGHT;
        end
      end
    end

    // Edge cells never select the missing neighbor; tie it off to a held word.
    if (i == 0) begin : g_first
      assign left_w = cell_word[i];
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == ple_pkg::Depth - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .value      (req.value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero read word, so OR them together.
  always_comb begin
    read_word = '0;
    for (int k = 0; k < ple_pkg::Depth; k++) begin
      read_word = read_word | cell_rd[k];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= dec.count_next;
    end
  end

  // Response register: load on a request transaction, drop on a response one.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= dec.status;
      rsp_read   <= read_word;
      rsp_count  <= dec.count_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = rsp_read;
  assign rsp.count      = rsp_count;

endmodule

[hw/rtl/ple_cell.sv]
module ple_cell (
  input  logic                              clk,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic signed [ple_pkg::WordW-1:0]  value,
  input  logic signed [ple_pkg::WordW-1:0]  left_word,
  input  logic signed [ple_pkg::WordW-1:0]  right_word,
  output logic signed [ple_pkg::WordW-1:0]  word,
  output logic signed [ple_pkg::WordW-1:0]  rd_word
);

  // Hold, load the new word, or take a neighbor's word.
  always_ff @(posedge clk) begin
    unique case (ctl.sel)
      ple_pkg::SEL_LOAD:  word <= value;
      ple_pkg::SEL_LEFT:  word <= left_word;
      ple_pkg::SEL_RIGHT: word <= right_word;
      default:            word <= word;
    endcase
  end

  assign rd_word = ctl.rd_en ? word : '0;

endmodule

[hw/rtl/ple_ctrl.sv]
module ple_ctrl (
  input  logic                          accept,
  input  logic [1:0]                    func,
  input  logic [ple_pkg::PosW-1:0]      position,
  input  logic [ple_pkg::CntW-1:0]      count,
  output ple_pkg::dec_t                 dec
);

  logic [ple_pkg::PosW:0] pos_x;
  logic [ple_pkg::PosW:0] cnt_x;
  logic                   empty;
  logic                   full;
  logic                   pos_zero;

  assign pos_x    = {1'b0, position};
  assign cnt_x    = (ple_pkg::PosW + 1)'(count);
  assign empty    = (count == '0);
  assign full     = (cnt_x >= (ple_pkg::PosW + 1)'(ple_pkg::Depth));
  assign pos_zero = (position == '0);

  always_comb begin
    dec            = '0;
    dec.status     = ple_pkg::ST_OK;
    dec.count_next = count;
    unique case (ple_pkg::op_t'(func))
      ple_pkg::OP_FIND: begin
        if (empty) begin
          dec.status = ple_pkg::ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          dec.status = ple_pkg::ST_BADPOS;
        end else begin
          dec.find_ok = accept;
        end
      end
      ple_pkg::OP_INSERT: begin
        if (full) begin
          dec.status = ple_pkg::ST_FULL;
        end else if (pos_zero || pos_x > cnt_x + 1'b1) begin
          dec.status = ple_pkg::ST_BADPOS;
        end else begin
          dec.ins_ok     = accept;
          dec.count_next = count + 1'b1;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (empty) begin
          dec.status = ple_pkg::ST_EMPTY;
        end else if (pos_zero || pos_x > cnt_x) begin
          dec.status = ple_pkg::ST_BADPOS;
        end else begin
          dec.del_ok     = accept;
          dec.count_next = count - 1'b1;
        end
      end
      default: begin
        dec.count_next = '0;
      end
    endcase
  end

endmodule

[hw/rtl/ple_check.sv]
`include "positional_list_engine_unit_assert.svh"

module ple_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [1:0]                        rsp_status,
  input logic signed [ple_pkg::WordW-1:0]  rsp_read_value,
  input logic [ple_pkg::CntW-1:0]          rsp_count
);

  `PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_count), "response changed while stalled")
  `PLE_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid, "accepted request gave no response in the next cycle")
  `PLE_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ple_pkg::ST_OK, rsp_read_value == '0, "error response carries a nonzero word")
  `PLE_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == ple_pkg::ST_FULL, rsp_count == ple_pkg::CntW'(ple_pkg::Depth), "full status without a full count")

endmodule

bind positional_list_engine_unit ple_check u_ple_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_read_value (rsp.read_value),
  .rsp_count      (rsp.count)
);

[tb/positional_list_engine_unit_test.sv]
module positional_list_engine_unit_test;

  // Expected response for one request transaction.
  typedef struct packed {
    ple_pkg::status_t                  status;
    logic signed [ple_pkg::WordW-1:0]  read_value;
    logic [ple_pkg::CntW-1:0]          count;
  } list_rsp_t;

  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int StuckLimit = 4000;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list, updated at each accepted request.
  logic signed [ple_pkg::WordW-1:0] shadow_words [ple_pkg::Depth];
  int                               shadow_count = 0;

  // Responses owed by the block, oldest first.
  list_rsp_t pending_rsp_q [$];

  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // Sender pacing: bursts of random length, separated by random gaps when sender_gaps is set.
  bit sender_gaps = 1'b1;
  int burst_left  = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one operation to the shadow list and return the response it earns.
  task automatic apply_list_op(input ple_pkg::op_t f, input logic [ple_pkg::PosW-1:0] p,
                               input logic signed [ple_pkg::WordW-1:0] v,
                               output list_rsp_t r);
    int pos;
    int j;
    pos = int'(p);
    r.status     = ple_pkg::ST_OK;
    r.read_value = '0;
    case (f)
      ple_pkg::OP_FIND: begin
        // Empty is flagged ahead of a bad position.
        if (shadow_count == 0) r.status = ple_pkg::ST_EMPTY;
        else if (pos < 1 || pos > shadow_count) r.status = ple_pkg::ST_BADPOS;
        else r.read_value = shadow_words[pos-1];
      end
      ple_pkg::OP_INSERT: begin
        // Full is flagged ahead of a bad position.
        if (shadow_count >= ple_pkg::Depth) r.status = ple_pkg::ST_FULL;
        else if (pos < 1 || pos > shadow_count + 1) r.status = ple_pkg::ST_BADPOS;
        else begin
          for (j = shadow_count; j >= pos; j--) shadow_words[j] = shadow_words[j-1];
          shadow_words[pos-1] = v;
          shadow_count++;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (shadow_count == 0) r.status = ple_pkg::ST_EMPTY;
        else if (pos < 1 || pos > shadow_count) r.status = ple_pkg::ST_BADPOS;
        else begin
          for (j = pos; j < shadow_count; j++) shadow_words[j-1] = shadow_words[j];
          shadow_count--;
        end
      end
      default: begin
        // Clear drops the count; stored words stay but leave the list.
        shadow_count = 0;
      end
    endcase
    r.count = shadow_count[ple_pkg::CntW-1:0];
  endtask

  // Check each response transaction against the oldest expectation, then
  // record the expectation for a request accepted at the same edge. The
  // block answers no earlier than the cycle after acceptance, so this order never pairs them wrongly.
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: status=%0d count=%0d",
                                  rsp_ch.status, rsp_ch.count));
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    rsp_ch.read_value, want.read_value));
        if (rsp_ch.count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", rsp_ch.count, want.count));
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      apply_list_op(ple_pkg::op_t'(req_ch.func), req_ch.position, req_ch.value, want);
      pending_rsp_q.push_back(want);
    end
  end

  // Watchdog: abandon the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no transaction for %0d cycles", StuckLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver back-pressure. When the current pattern runs out, pick a new one: always
  // ready, coin flip, mostly stalled, or runs of ready/stall of random length.
  always @(negedge clk) begin
    static int pattern_left = 0;
    static int stall_mode   = 0;
    static int run_left     = 0;
    static bit run_ready    = 1'b1;
    if (pattern_left == 0) begin
      stall_mode   = $urandom_range(0, 3);
      pattern_left = 64;
    end
    pattern_left--;
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_ready = ~run_ready;
          run_left  = $urandom_range(1, 8);
        end
        run_left--;
        rsp_ch.ready <= run_ready;
      end
    endcase
  end

  // Send one request. Enter and leave at a falling edge; valid stays high
  // after the transaction so back-to-back items keep it asserted.
  task automatic send_list_op(input ple_pkg::op_t f, input logic [ple_pkg::PosW-1:0] p,
                              input logic signed [ple_pkg::WordW-1:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= f;
    req_ch.position <= p;
    req_ch.value    <= v;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed response has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_rsp_q.size() != 0);
  endtask

  // Every operation on an empty list, with position extremes.
  task automatic test_empty_list();
    send_list_op(ple_pkg::OP_FIND,   8'd1,   32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd0,   32'sd0);   // empty wins over bad position
    send_list_op(ple_pkg::OP_DELETE, 8'd1,   32'sd0);
    send_list_op(ple_pkg::OP_DELETE, 8'd0,   32'sd0);
    send_list_op(ple_pkg::OP_CLEAR,  8'd0,   32'sd0);
    send_list_op(ple_pkg::OP_INSERT, 8'd0,   32'sd5);   // position zero
    send_list_op(ple_pkg::OP_INSERT, 8'd2,   32'sd5);   // beyond count+1
    send_list_op(ple_pkg::OP_INSERT, 8'd255, 32'sd5);
  endtask

  // Insert at front, middle and tail, read back, delete and clear.
  task automatic test_basic_edits();
    send_list_op(ple_pkg::OP_INSERT, 8'd1, 32'sh7FFF_FFFF);
    send_list_op(ple_pkg::OP_INSERT, 8'd2, 32'sh8000_0000);
    send_list_op(ple_pkg::OP_INSERT, 8'd1, -32'sd1);
    send_list_op(ple_pkg::OP_INSERT, 8'd2, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd1, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd4, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd0, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd5, 32'sd0);     // one past the end
    send_list_op(ple_pkg::OP_DELETE, 8'd2, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd2, 32'sd0);
    send_list_op(ple_pkg::OP_DELETE, 8'd4, 32'sd0);     // one past the end
    send_list_op(ple_pkg::OP_DELETE, 8'd3, 32'sd0);     // tail
    send_list_op(ple_pkg::OP_FIND,   8'd255, 32'sd0);
    send_list_op(ple_pkg::OP_CLEAR,  8'd77, 32'sd9);
    send_list_op(ple_pkg::OP_FIND,   8'd1, 32'sd0);
  endtask

  // Fill to capacity, then probe the full-list boundaries.
  task automatic test_full_list();
    while (shadow_count < ple_pkg::Depth)
      send_list_op(ple_pkg::OP_INSERT,
                   ple_pkg::PosW'($urandom_range(1, shadow_count + 1)), $urandom);
    send_list_op(ple_pkg::OP_INSERT, 8'd1, 32'sd3);
    send_list_op(ple_pkg::OP_INSERT, 8'd0, 32'sd3);     // full wins over bad position
    send_list_op(ple_pkg::OP_INSERT, 8'd255, 32'sd3);
    send_list_op(ple_pkg::OP_FIND,   ple_pkg::PosW'(ple_pkg::Depth), 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   ple_pkg::PosW'(ple_pkg::Depth + 1), 32'sd0);
    send_list_op(ple_pkg::OP_DELETE, ple_pkg::PosW'(ple_pkg::Depth + 1), 32'sd0);
    send_list_op(ple_pkg::OP_DELETE, ple_pkg::PosW'(ple_pkg::Depth), 32'sd0);
    send_list_op(ple_pkg::OP_INSERT, ple_pkg::PosW'(ple_pkg::Depth), 32'sh8000_0000);
    send_list_op(ple_pkg::OP_FIND,   ple_pkg::PosW'(ple_pkg::Depth), 32'sd0);
    send_list_op(ple_pkg::OP_DELETE, 8'd1, 32'sd0);
    send_list_op(ple_pkg::OP_FIND,   8'd1, 32'sd0);
    send_list_op(ple_pkg::OP_CLEAR,  8'd255, 32'sd0);
  endtask

  // Random traffic in chunks that alternately grow and shrink the list.
  // Most positions fall in the legal range; a tenth are arbitrary.
  task automatic test_random_traffic(input int n_items);
    int i;
    int pick;
    int w_find, w_ins, w_del;
    ple_pkg::op_t f;
    logic [ple_pkg::PosW-1:0] p;
    for (i = 0; i < n_items; i++) begin
      if (i % 300 == 0) begin
        if ((i / 300) % 2 == 0) begin
          w_find = 30; w_ins = 55; w_del = 15;   // no clear: let it fill up
        end else begin
          w_find = 30; w_ins = 20; w_del = 45;
        end
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      // Pause the sender until the block has answered everything.
      if (i % 500 == 250) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < w_find) f = ple_pkg::OP_FIND;
      else if (pick < w_find + w_ins) f = ple_pkg::OP_INSERT;
      else if (pick < w_find + w_ins + w_del) f = ple_pkg::OP_DELETE;
      else f = ple_pkg::OP_CLEAR;
      if ($urandom_range(0, 9) == 0) p = ple_pkg::PosW'($urandom_range(0, 255));
      else if (f == ple_pkg::OP_INSERT)
        p = ple_pkg::PosW'($urandom_range(1, shadow_count + 1));
      else if (shadow_count > 0) p = ple_pkg::PosW'($urandom_range(1, shadow_count));
      else p = 8'd1;
      send_list_op(f, p, $urandom);
    end
  endtask

  initial begin
    // Hold the reset and request inputs at a known value from time zero.
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.func     = ple_pkg::OP_FIND;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_basic_edits();
    test_full_list();
    test_random_traffic(2000);

    // Drain, then let the block run on idle so that anything stray shows.
    hold_until_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_if.sv
hw/rtl/ple_cell.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine_unit.sv
hw/rtl/ple_check.sv
tb/positional_list_engine_unit_test.sv
